// ----- hw/rtl/pma_pkg.sv -----
package pma_pkg;

    // Field widths fixed by the sample and result formats
    localparam int POS_W  = 16;
    localparam int HELD_W = 5;
    localparam int QUO_W  = 16;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_pos_in;

    typedef struct packed {
        logic signed [POS_W-1:0] avg_x;
        logic signed [POS_W-1:0] avg_y;
        logic [HELD_W-1:0]       samples_held;
    } t_avg_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START_X,
        ST_WAIT_X,
        ST_START_Y,
        ST_WAIT_Y,
        ST_PUSH
    } t_pma_state;

endpackage

// ----- hw/rtl/position_moving_average.sv -----
// An accepted sample passes the update, x divide, y divide and push states before
// its result is loaded into the output register; the shared divider runs 16 steps
// for x, then 16 for y, plus load and handoff states. No new sample is taken before the last is pushed.
// Input stall is high while a sample is in process; a new sample is taken while
// a finished result still waits in the output register.
// Reset (synchronous, active low) empties the window and clears the running sums.
module position_moving_average #(
    parameter int WINDOW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pma_pkg::t_pos_in    i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pma_pkg::t_avg_out   o_out_data
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = 17 + SLOT_W;
    localparam int POS_W  = pma_pkg::POS_W;

    pma_pkg::t_pma_state     r_state;
    pma_pkg::t_pma_state     n_state;
    logic [SLOT_W-1:0]       r_slot;
    logic [CNT_W-1:0]        r_fill;
    logic signed [SUM_W-1:0] r_sum_x;
    logic signed [SUM_W-1:0] r_sum_y;
    logic signed [SUM_W-1:0] n_sum_x;
    logic signed [SUM_W-1:0] n_sum_y;
    pma_pkg::t_pos_in        r_new;
    logic signed [POS_W-1:0] r_qx;
    logic                    r_out_valid;
    pma_pkg::t_avg_out       r_out_data;

    logic                    accept;
    logic                    rd_en;
    logic                    wr_en;
    logic                    div_start;
    logic                    load_out;
    logic                    full;
    pma_pkg::t_pos_in        old_sample;
    logic                    div_done;
    logic signed [POS_W-1:0] div_quo;

    assign accept = i_in_valid && !o_in_stall;
    assign full   = (r_fill == CNT_W'(WINDOW));

    pma_ring #(
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_new),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_slot),
        .o_rd_data (old_sample)
    );

    pma_div #(
        .SUM_W (SUM_W),
        .DIV_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ((r_state == pma_pkg::ST_START_Y) ? r_sum_y : r_sum_x),
        .i_divisor  (r_fill),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pma_pkg::ST_IDLE:    if (accept) n_state = pma_pkg::ST_UPDATE;
            pma_pkg::ST_UPDATE:  n_state = pma_pkg::ST_START_X;
            pma_pkg::ST_START_X: n_state = pma_pkg::ST_WAIT_X;
            pma_pkg::ST_WAIT_X:  if (div_done) n_state = pma_pkg::ST_START_Y;
            pma_pkg::ST_START_Y: n_state = pma_pkg::ST_WAIT_Y;
            pma_pkg::ST_WAIT_Y:  if (div_done) n_state = pma_pkg::ST_PUSH;
            pma_pkg::ST_PUSH:    if (load_out) n_state = pma_pkg::ST_IDLE;
            default:             n_state = pma_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            pma_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                rd_en      = i_in_valid;
            end
            pma_pkg::ST_UPDATE:  wr_en = 1'b1;
            pma_pkg::ST_START_X: div_start = 1'b1;
            pma_pkg::ST_START_Y: div_start = 1'b1;
            pma_pkg::ST_PUSH:    load_out = !r_out_valid || !i_out_stall;
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Drop the oldest sample once the window is full, add the new one
    always_comb begin
        n_sum_x = r_sum_x + SUM_W'(r_new.pos_x);
        n_sum_y = r_sum_y + SUM_W'(r_new.pos_y);
        if (full) begin
            n_sum_x = n_sum_x - SUM_W'(old_sample.pos_x);
            n_sum_y = n_sum_y - SUM_W'(old_sample.pos_y);
        end
    end

    // Control state and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pma_pkg::ST_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_slot  <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (!full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the sample, the x mean and the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_new <= i_in_data;
        end
        if (r_state == pma_pkg::ST_WAIT_X && div_done) begin
            r_qx <= div_quo;
        end
        if (load_out) begin
            r_out_data.avg_x        <= r_qx;
            r_out_data.avg_y        <= div_quo;
            r_out_data.samples_held <= pma_pkg::HELD_W'(r_fill);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- hw/rtl/pma_ring.sv -----
module pma_ring #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  pma_pkg::t_pos_in           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output pma_pkg::t_pos_in           o_rd_data
);

    pma_pkg::t_pos_in r_mem [DEPTH];
    pma_pkg::t_pos_in r_rd_data;

    // Write one sample slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read of the oldest sample
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/pma_div.sv -----
module pma_div #(
    parameter int SUM_W = 21,
    parameter int DIV_W = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [SUM_W-1:0]         i_dividend,
    input  logic [DIV_W-1:0]                i_divisor,
    output logic                            o_done,
    output logic signed [pma_pkg::QUO_W-1:0] o_quotient
);

    localparam int QW    = pma_pkg::QUO_W;
    localparam int REM_W = DIV_W + 1;
    localparam int STP_W = $clog2(QW);

    logic               r_busy;
    logic               r_done;
    logic [STP_W-1:0]   r_step;
    logic [REM_W-1:0]   r_rem;
    logic [QW-1:0]      r_quo;
    logic [DIV_W-1:0]   r_div;
    logic               r_neg;

    logic [SUM_W-1:0]   mag;
    logic [REM_W-1:0]   trial;
    logic               fits;

    // Magnitude of the signed dividend
    assign mag = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;

    // One restoring step: shift in the next dividend bit and try the subtract
    assign trial = {r_rem[REM_W-2:0], r_quo[QW-1]};
    assign fits  = trial >= {1'b0, r_div};

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STP_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load the operands, then advance remainder and quotient one bit a cycle.
    // The mean fits QW bits, so the bits above them start out as remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_div <= i_divisor;
            r_rem <= REM_W'(mag[SUM_W-1:QW]);
            r_quo <= mag[QW-1:0];
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_div}) : trial;
            r_quo <= {r_quo[QW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

// ----- hw/rtl/pma_chk.sv -----
module pma_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input pma_pkg::t_pos_in  i_in_data,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input pma_pkg::t_avg_out o_out_data
);

    // A stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    // A stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled input transaction changed or dropped");

    // The block goes busy right after taking a sample
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second sample taken while busy");

    // Every result reports at least one held sample
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.samples_held != '0))
        else $error("result with empty window");

endmodule

bind position_moving_average pma_chk u_pma_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
